FILE: design/hsv_pkg.sv
package hsv_pkg;

    // input and output widths
    localparam int HUE_W    = 16;
    localparam int FRAC_W   = 9;
    localparam int CHAN_W   = 8;

    // internal widths
    localparam int HOFF_W   = 17;   // offset hue, always positive
    localparam int HWRAP_W  = 14;   // hue wrapped into one turn
    localparam int POS_W    = 11;   // position inside a sector, 0..1920
    localparam int SECT_W   = 3;    // sector number 0..5
    localparam int CHROMA_W = 17;   // value * saturation, 0..65536
    localparam int SUM_W    = 27;   // channel in units of 1/(65536*1920)
    localparam int PROD_W   = 35;   // channel sum times 255
    localparam int QUOT_W   = 12;   // product shifted down by 2^23
    localparam int RECIP_W  = 14;
    localparam int RPROD_W  = 26;

    // hue constants in 1/32 degree
    localparam int HUE_FULL   = 11520;
    localparam int HUE_SECTOR = 1920;
    localparam int HUE_OFFSET = 3 * HUE_FULL;  // lifts any 16-bit hue above zero

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(256);

    // division by 15 as multiply by reciprocal, exact for inputs below 10082
    localparam logic [RECIP_W-1:0] RECIP_15  = RECIP_W'(8739);
    localparam int                 RECIP_SHF = 17;
    localparam int                 DIV_SHF   = 23;  // 65536*1920 = 2^23 * 15

    // sector codes
    localparam logic [SECT_W-1:0] SECT_RED_YEL  = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN  = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN  = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU  = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG  = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED  = 3'd5;

    // hue decode result handed to the mixer
    typedef struct packed {
        logic [SECT_W-1:0]   sector;
        logic [POS_W-1:0]    frac;     // weight of the intermediate component
        logic [CHROMA_W-1:0] chroma;
        logic [FRAC_W-1:0]   bright;
    } t_hue_pos;

    // channel sums handed to the scaler
    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } t_chan_sum;

endpackage

FILE: design/hsv_sector.sv
module hsv_sector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hsv_pkg::HUE_W-1:0]    i_hue,
    input  logic [hsv_pkg::FRAC_W-1:0]   i_saturation,
    input  logic [hsv_pkg::FRAC_W-1:0]   i_brightness,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hsv_pkg::t_hue_pos            o_pos
);
    import hsv_pkg::*;

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    logic [HOFF_W-1:0]   r_hoff, n_hoff;
    logic [FRAC_W-1:0]   r_sat1, n_sat1;
    logic [FRAC_W-1:0]   r_bri1, n_bri1;
    logic [HWRAP_W-1:0]  r_hwrap, n_hwrap;
    logic [CHROMA_W-1:0] r_chroma2, n_chroma2;
    logic [FRAC_W-1:0]   r_bri2;
    t_hue_pos            r_pos, n_pos;

    logic [HOFF_W-1:0]   wrap_sub;
    logic [HWRAP_W-1:0]  sect_sub;
    logic [POS_W-1:0]    in_sect;
    logic [SECT_W-1:0]   sector;

    // stage enables, a stage moves when empty or when the next one moves
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_pos   = r_pos;

    // stage 1: clamp fractions, offset hue to a positive value
    always_comb begin
        n_hoff = HOFF_W'($signed({{2{i_hue[HUE_W-1]}}, i_hue}) + 18'(HUE_OFFSET));
        n_sat1 = (i_saturation > FRAC_ONE) ? FRAC_ONE : i_saturation;
        n_bri1 = (i_brightness > FRAC_ONE) ? FRAC_ONE : i_brightness;
    end

    // stage 2: wrap hue into one turn, form chroma
    always_comb begin
        priority if (r_hoff >= HOFF_W'(5 * HUE_FULL)) begin
            wrap_sub = HOFF_W'(5 * HUE_FULL);
        end else if (r_hoff >= HOFF_W'(4 * HUE_FULL)) begin
            wrap_sub = HOFF_W'(4 * HUE_FULL);
        end else if (r_hoff >= HOFF_W'(3 * HUE_FULL)) begin
            wrap_sub = HOFF_W'(3 * HUE_FULL);
        end else if (r_hoff >= HOFF_W'(2 * HUE_FULL)) begin
            wrap_sub = HOFF_W'(2 * HUE_FULL);
        end else if (r_hoff >= HOFF_W'(HUE_FULL)) begin
            wrap_sub = HOFF_W'(HUE_FULL);
        end else begin
            wrap_sub = '0;
        end
        n_hwrap   = HWRAP_W'(r_hoff - wrap_sub);
        n_chroma2 = CHROMA_W'(CHROMA_W'(r_sat1) * CHROMA_W'(r_bri1));
    end

    // stage 3: sector and weight of the intermediate component
    always_comb begin
        priority if (r_hwrap >= HWRAP_W'(5 * HUE_SECTOR)) begin
            sector   = SECT_MAG_RED;
            sect_sub = HWRAP_W'(5 * HUE_SECTOR);
        end else if (r_hwrap >= HWRAP_W'(4 * HUE_SECTOR)) begin
            sector   = SECT_BLU_MAG;
            sect_sub = HWRAP_W'(4 * HUE_SECTOR);
        end else if (r_hwrap >= HWRAP_W'(3 * HUE_SECTOR)) begin
            sector   = SECT_CYN_BLU;
            sect_sub = HWRAP_W'(3 * HUE_SECTOR);
        end else if (r_hwrap >= HWRAP_W'(2 * HUE_SECTOR)) begin
            sector   = SECT_GRN_CYN;
            sect_sub = HWRAP_W'(2 * HUE_SECTOR);
        end else if (r_hwrap >= HWRAP_W'(HUE_SECTOR)) begin
            sector   = SECT_YEL_GRN;
            sect_sub = HWRAP_W'(HUE_SECTOR);
        end else begin
            sector   = SECT_RED_YEL;
            sect_sub = '0;
        end
        in_sect = POS_W'(r_hwrap - sect_sub);
        // rising component in even sectors, falling in odd ones
        n_pos.sector = sector;
        n_pos.frac   = sector[0] ? POS_W'(POS_W'(HUE_SECTOR) - in_sect) : in_sect;
        n_pos.chroma = r_chroma2;
        n_pos.bright = r_bri2;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_hoff <= n_hoff;
            r_sat1 <= n_sat1;
            r_bri1 <= n_bri1;
        end
        if (en2) begin
            r_hwrap   <= n_hwrap;
            r_chroma2 <= n_chroma2;
            r_bri2    <= r_bri1;
        end
        if (en3) begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: design/hsv_mix.sv
module hsv_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hsv_pkg::t_hue_pos  i_pos,
    output logic               o_valid,
    input  logic               i_ready,
    output hsv_pkg::t_chan_sum o_sum
);
    import hsv_pkg::*;

    logic en4, en5;
    logic r_v4, r_v5;

    logic [SUM_W-1:0]  r_cs, n_cs;
    logic [SUM_W-1:0]  r_xs, n_xs;
    logic [SUM_W-1:0]  r_ms, n_ms;
    logic [SECT_W-1:0] r_sector;
    t_chan_sum         r_sum, n_sum;

    logic [SUM_W-1:0]  sel_r, sel_g, sel_b;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v5;
    assign o_sum   = r_sum;

    // stage 4: chroma, intermediate and offset terms on a common scale
    always_comb begin
        n_cs = SUM_W'(SUM_W'(i_pos.chroma) * SUM_W'(HUE_SECTOR));
        n_xs = SUM_W'(SUM_W'(i_pos.chroma) * SUM_W'(i_pos.frac));
        n_ms = SUM_W'((SUM_W'({i_pos.bright, 8'b0}) - SUM_W'(i_pos.chroma))
                      * SUM_W'(HUE_SECTOR));
    end

    // stage 5: component order by sector, then add the offset
    always_comb begin
        unique case (r_sector)
            SECT_RED_YEL: begin sel_r = r_cs; sel_g = r_xs; sel_b = '0;   end
            SECT_YEL_GRN: begin sel_r = r_xs; sel_g = r_cs; sel_b = '0;   end
            SECT_GRN_CYN: begin sel_r = '0;   sel_g = r_cs; sel_b = r_xs; end
            SECT_CYN_BLU: begin sel_r = '0;   sel_g = r_xs; sel_b = r_cs; end
            SECT_BLU_MAG: begin sel_r = r_xs; sel_g = '0;   sel_b = r_cs; end
            default:      begin sel_r = r_cs; sel_g = '0;   sel_b = r_xs; end
        endcase
        n_sum.red   = sel_r + r_ms;
        n_sum.green = sel_g + r_ms;
        n_sum.blue  = sel_b + r_ms;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_cs     <= n_cs;
            r_xs     <= n_xs;
            r_ms     <= n_ms;
            r_sector <= i_pos.sector;
        end
        if (en5) begin
            r_sum <= n_sum;
        end
    end

endmodule

FILE: design/hsv_scale.sv
module hsv_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  hsv_pkg::t_chan_sum          i_sum,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hsv_pkg::CHAN_W-1:0]  o_red,
    output logic [hsv_pkg::CHAN_W-1:0]  o_green,
    output logic [hsv_pkg::CHAN_W-1:0]  o_blue
);
    import hsv_pkg::*;

    logic en6, en7;
    logic r_v6, r_v7;

    logic [SUM_W-1:0]   lane_sum [3];
    logic [PROD_W-1:0]  lane_prod [3];
    logic [QUOT_W-1:0]  r_quot [3];
    logic [QUOT_W-1:0]  n_quot [3];
    logic [RPROD_W-1:0] lane_rprod [3];
    logic [CHAN_W-1:0]  r_chan [3];
    logic [CHAN_W-1:0]  n_chan [3];

    assign en7     = !r_v7 || i_ready;
    assign en6     = !r_v6 || en7;
    assign o_ready = en6;
    assign o_valid = r_v7;
    assign o_red   = r_chan[0];
    assign o_green = r_chan[1];
    assign o_blue  = r_chan[2];

    assign lane_sum[0] = i_sum.red;
    assign lane_sum[1] = i_sum.green;
    assign lane_sum[2] = i_sum.blue;

    // stage 6: times 255, then drop the power-of-two part of the divisor
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lane_prod[i] = {lane_sum[i], 8'b0} - PROD_W'(lane_sum[i]);
            n_quot[i]    = lane_prod[i][DIV_SHF +: QUOT_W];
        end
    end

    // stage 7: divide by 15 through the reciprocal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lane_rprod[i] = RPROD_W'(RPROD_W'(r_quot[i]) * RPROD_W'(RECIP_15));
            n_chan[i]     = lane_rprod[i][RECIP_SHF +: CHAN_W];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (en6) r_v6 <= i_valid;
            if (en7) r_v7 <= r_v6;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (en6) r_quot[i] <= n_quot[i];
            if (en7) r_chan[i] <= n_chan[i];
        end
    end

endmodule

FILE: design/hsv_to_rgb_converter.sv
// hsv to rgb pixel converter
// input stream: one request per pixel on the slave group, hue (signed,
// 1/32 degree, any value wraps modulo 360 degrees), saturation and
// brightness (256 means full, larger values clamp to full)
// output stream: one request per pixel on the master group with 8-bit
// red, green and blue, in the same order as the input
// throughput: one pixel per clock while the receiver keeps tready high;
// every stage has its own valid bit and moves whenever it is empty or the
// stage after it moves; pipeline stages from input accept to output valid,
// in order: hue offset, hue wrap, sector decode, chroma products, channel
// select and offset add, scale by 255, divide by 15
// stall: when the receiver holds tready low, the output stage holds its
// pixel and the stages behind it keep filling; the input tready drops only
// once every stage holds a pixel, so nothing is lost or repeated
// reset: synchronous, active low; clears all valid bits, the payload
// registers have no reset, and the block is ready on the first cycle after reset
module hsv_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // hue[15:0], saturation[24:16], brightness[33:25]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsv_pkg::*;

    logic      sect_valid, sect_ready;
    t_hue_pos  sect_pos;
    logic      mix_valid, mix_ready;
    t_chan_sum mix_sum;
    logic [CHAN_W-1:0] red, green, blue;

    // hue wrap and sector decode
    hsv_sector u_sector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_hue        (i_s_axis_tdata[15:0]),
        .i_saturation (i_s_axis_tdata[24:16]),
        .i_brightness (i_s_axis_tdata[33:25]),
        .o_valid      (sect_valid),
        .i_ready      (mix_ready),
        .o_pos        (sect_pos)
    );

    // component products and channel order
    hsv_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sect_valid),
        .o_ready (mix_ready),
        .i_pos   (sect_pos),
        .o_valid (mix_valid),
        .i_ready (sect_ready),
        .o_sum   (mix_sum)
    );

    // scale to 8-bit channels
    hsv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .o_ready (sect_ready),
        .i_sum   (mix_sum),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    assign o_m_axis_tdata = {blue, green, red};

endmodule
